[src/aabb_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_pkg
// shared widths, register codes and types of the clip-space box culling unit
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int COORD_W     = 16;            // signed q8.8 coordinate or coefficient
	localparam int PROD_W      = 2 * COORD_W;   // one exact product
	localparam int PAIR_W      = PROD_W + 1;    // sum of two products
	localparam int CLIP_W      = PROD_W + 2;    // sum of four products
	localparam int CMP_W       = CLIP_W + 1;    // room for h +/- w
	localparam int NUM_REGS    = 8;
	localparam int NUM_CORNERS = 8;
	localparam int NUM_PLANES  = 6;
	localparam int NUM_ROWS    = 4;
	localparam int IDX_W       = 4;             // wide enough to see writes beyond the list
	localparam int DATA_W      = 32;
	localparam int W_SHIFT     = 8;             // w = 1.0 in q8.8

	// register indexes
	localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
	localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
	localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

	// reset matrix is the identity
	localparam logic [DATA_W-1:0] RST_ROW0_COLS01 = 32'h0000_0100;
	localparam logic [DATA_W-1:0] RST_ROW0_COLS23 = 32'h0000_0000;
	localparam logic [DATA_W-1:0] RST_ROW1_COLS01 = 32'h0100_0000;
	localparam logic [DATA_W-1:0] RST_ROW1_COLS23 = 32'h0000_0000;
	localparam logic [DATA_W-1:0] RST_ROW2_COLS01 = 32'h0000_0000;
	localparam logic [DATA_W-1:0] RST_ROW2_COLS23 = 32'h0000_0100;
	localparam logic [DATA_W-1:0] RST_ROW3_COLS01 = 32'h0000_0000;
	localparam logic [DATA_W-1:0] RST_ROW3_COLS23 = 32'h0100_0000;

	// plane bit positions
	localparam int PLANE_LEFT   = 0;
	localparam int PLANE_RIGHT  = 1;
	localparam int PLANE_BOTTOM = 2;
	localparam int PLANE_TOP    = 3;
	localparam int PLANE_NEAR   = 4;
	localparam int PLANE_FAR    = 5;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CLIP_W-1:0]  clip_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

endpackage

[src/aabb_clip_space_visibility_test_unit.sv]
// ----------------------------------------------------------------------------
// aabb_clip_space_visibility_test_unit
// frustum culling of an axis-aligned box by clip-space outcodes
// ----------------------------------------------------------------------------
// a box taken on start passes the stage 1, 2 and 3 registers, then done and the result are registered
// throughput: one box per cycle, every stage takes a new box each cycle and nothing stalls
// busy stays low, and results cannot be held off by the receiver
// reset clears the pipeline valid bits and loads the identity matrix
// configuration writes are always ready and take effect at the edge of the transfer
// ----------------------------------------------------------------------------
module aabb_clip_space_visibility_test_unit
	import aabb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// box channel
	input  logic              start,
	output logic              busy,
	input  coord_t            min_x,
	input  coord_t            min_y,
	input  coord_t            min_z,
	input  coord_t            max_x,
	input  coord_t            max_y,
	input  coord_t            max_z,
	// result channel
	output logic              done,
	output logic              visible,
	output logic [NUM_PLANES-1:0] all_outside_planes,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	localparam int HALF_W = DATA_W / 2;

	// matrix registers, one word per row half
	logic [DATA_W-1:0] row0_cols01_q, row0_cols23_q;
	logic [DATA_W-1:0] row1_cols01_q, row1_cols23_q;
	logic [DATA_W-1:0] row2_cols01_q, row2_cols23_q;
	logic [DATA_W-1:0] row3_cols01_q, row3_cols23_q;

	// pipeline valid bits travel beside the datapath stages
	logic valid_s1, valid_s2, valid_s3;

	// result registers
	logic                  done_q;
	logic                  visible_q;
	logic [NUM_PLANES-1:0] planes_q;

	box_t   box;
	coord_t coef [NUM_ROWS][NUM_ROWS];
	clip_t  clip_s3 [NUM_ROWS][NUM_CORNERS];
	logic [NUM_PLANES-1:0] mask;

	// the pipeline never stalls, so the unit is never busy
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// configuration: an index beyond the list is dropped
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_cols01_q <= RST_ROW0_COLS01;
			row0_cols23_q <= RST_ROW0_COLS23;
			row1_cols01_q <= RST_ROW1_COLS01;
			row1_cols23_q <= RST_ROW1_COLS23;
			row2_cols01_q <= RST_ROW2_COLS01;
			row2_cols23_q <= RST_ROW2_COLS23;
			row3_cols01_q <= RST_ROW3_COLS01;
			row3_cols23_q <= RST_ROW3_COLS23;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW0_COLS01: row0_cols01_q <= cfg_data;
				REG_ROW0_COLS23: row0_cols23_q <= cfg_data;
				REG_ROW1_COLS01: row1_cols01_q <= cfg_data;
				REG_ROW1_COLS23: row1_cols23_q <= cfg_data;
				REG_ROW2_COLS01: row2_cols01_q <= cfg_data;
				REG_ROW2_COLS23: row2_cols23_q <= cfg_data;
				REG_ROW3_COLS01: row3_cols01_q <= cfg_data;
				REG_ROW3_COLS23: row3_cols23_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// split the words into q8.8 coefficients, lower column in the low half
	always_comb begin
		coef[0][0] = coord_t'(row0_cols01_q[HALF_W-1:0]);
		coef[0][1] = coord_t'(row0_cols01_q[DATA_W-1:HALF_W]);
		coef[0][2] = coord_t'(row0_cols23_q[HALF_W-1:0]);
		coef[0][3] = coord_t'(row0_cols23_q[DATA_W-1:HALF_W]);
		coef[1][0] = coord_t'(row1_cols01_q[HALF_W-1:0]);
		coef[1][1] = coord_t'(row1_cols01_q[DATA_W-1:HALF_W]);
		coef[1][2] = coord_t'(row1_cols23_q[HALF_W-1:0]);
		coef[1][3] = coord_t'(row1_cols23_q[DATA_W-1:HALF_W]);
		coef[2][0] = coord_t'(row2_cols01_q[HALF_W-1:0]);
		coef[2][1] = coord_t'(row2_cols01_q[DATA_W-1:HALF_W]);
		coef[2][2] = coord_t'(row2_cols23_q[HALF_W-1:0]);
		coef[2][3] = coord_t'(row2_cols23_q[DATA_W-1:HALF_W]);
		coef[3][0] = coord_t'(row3_cols01_q[HALF_W-1:0]);
		coef[3][1] = coord_t'(row3_cols01_q[DATA_W-1:HALF_W]);
		coef[3][2] = coord_t'(row3_cols23_q[HALF_W-1:0]);
		coef[3][3] = coord_t'(row3_cols23_q[DATA_W-1:HALF_W]);
	end

	assign box = '{min_x: min_x, min_y: min_y, min_z: min_z,
		max_x: max_x, max_y: max_y, max_z: max_z};

	// ------------------------------------------------------------------
	// stages 1 to 3: one transform pipeline per matrix row, x y z w
	// ------------------------------------------------------------------
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		aabb_row_xform u_row (
			.clk     (clk),
			.coef    (coef[r]),
			.box     (box),
			.clip_s3 (clip_s3[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: outcodes per corner, and across all corners
	// x < -w  is  x + w < 0 ; x > w  is  w - x < 0
	// ------------------------------------------------------------------
	always_comb begin
		logic signed [CMP_W-1:0] wc;
		logic signed [CMP_W-1:0] below [3];
		logic signed [CMP_W-1:0] above [3];
		logic [NUM_PLANES-1:0]   code;
		mask = '1;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			wc = CMP_W'(clip_s3[3][i]);
			for (int a = 0; a < 3; a++) begin
				below[a] = CMP_W'(clip_s3[a][i]) + wc;
				above[a] = wc - CMP_W'(clip_s3[a][i]);
			end
			code[PLANE_LEFT]   = below[0][CMP_W-1];
			code[PLANE_RIGHT]  = above[0][CMP_W-1];
			code[PLANE_BOTTOM] = below[1][CMP_W-1];
			code[PLANE_TOP]    = above[1][CMP_W-1];
			code[PLANE_NEAR]   = below[2][CMP_W-1];
			code[PLANE_FAR]    = above[2][CMP_W-1];
			mask = mask & code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	// result payload, held until the next transfer
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			planes_q  <= mask;
			visible_q <= (mask == '0);
		end
	end

	assign done               = done_q;
	assign visible            = visible_q;
	assign all_outside_planes = planes_q;

endmodule

[src/aabb_row_xform.sv]
// ----------------------------------------------------------------------------
// aabb_row_xform
// one matrix row applied to all eight box corners, three register stages
// ----------------------------------------------------------------------------
module aabb_row_xform
	import aabb_pkg::*;
(
	input  logic  clk,
	input  coord_t coef [NUM_ROWS],
	input  box_t  box,
	output clip_t clip_s3 [NUM_CORNERS]
);

	localparam int NUM_XY = 4;
	localparam int NUM_ZW = 2;

	logic signed [PROD_W-1:0] lo_x_s1, lo_y_s1, lo_z_s1;
	logic signed [PROD_W-1:0] hi_x_s1, hi_y_s1, hi_z_s1;
	logic signed [PROD_W-1:0] w_s1;
	logic signed [PAIR_W-1:0] xy_s2 [NUM_XY];
	logic signed [PAIR_W-1:0] zw_s2 [NUM_ZW];

	// stage 1: one product per axis, per min and max
	always_ff @(posedge clk) begin
		lo_x_s1 <= coef[0] * box.min_x;
		hi_x_s1 <= coef[0] * box.max_x;
		lo_y_s1 <= coef[1] * box.min_y;
		hi_y_s1 <= coef[1] * box.max_y;
		lo_z_s1 <= coef[2] * box.min_z;
		hi_z_s1 <= coef[2] * box.max_z;
		w_s1    <= PROD_W'(coef[3]) <<< W_SHIFT;
	end

	// stage 2: x+y for the four x/y choices, z+w for the two z choices
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_XY; k++) begin
			xy_s2[k] <= PAIR_W'(k[0] ? hi_x_s1 : lo_x_s1) +
				PAIR_W'(k[1] ? hi_y_s1 : lo_y_s1);
		end
		zw_s2[0] <= PAIR_W'(lo_z_s1) + PAIR_W'(w_s1);
		zw_s2[1] <= PAIR_W'(hi_z_s1) + PAIR_W'(w_s1);
	end

	// stage 3: full clip coordinate of each corner
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			clip_s3[i] <= CLIP_W'(xy_s2[i % NUM_XY]) + CLIP_W'(zw_s2[i / NUM_XY]);
		end
	end

endmodule

[verif/aabb_clip_space_visibility_test_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_clip_space_visibility_test_unit_test
// self-checking bench for the clip-space box culling unit: directed corner and
// boundary boxes, then random boxes under a series of matrix settings, each
// result compared against an in-bench outcode predictor
// ----------------------------------------------------------------------------
module aabb_clip_space_visibility_test_unit_test;
	import aabb_pkg::*;

	localparam int RESET_CYCLES = 8;
	localparam int PHASE_BOXES  = 210;
	localparam int STALL_LIMIT  = 1000;   // cycles with no transfer at all
	localparam int DRAIN_CYCLES = 8;      // pipeline is four deep

	// register index of each matrix row, lower column pair first
	localparam logic [IDX_W-1:0] ROW_REG [NUM_ROWS][2] = '{
		'{REG_ROW0_COLS01, REG_ROW0_COLS23},
		'{REG_ROW1_COLS01, REG_ROW1_COLS23},
		'{REG_ROW2_COLS01, REG_ROW2_COLS23},
		'{REG_ROW3_COLS01, REG_ROW3_COLS23}
	};

	// coordinates that sit on or next to the extremes and the unit planes
	localparam coord_t EDGE_VALS [7] = '{
		16'sh8000, 16'sh7fff, 16'sh0000, -16'sd256, 16'sd256, -16'sd257, 16'sd257
	};

	typedef enum {
		MAT_IDENTITY, MAT_ZERO, MAT_MOST_NEG, MAT_MOST_POS,
		MAT_RANDOM, MAT_PERSPECTIVE, MAT_SMALL
	} matrix_kind_t;

	localparam matrix_kind_t PHASE_KINDS [8] = '{
		MAT_RANDOM, MAT_PERSPECTIVE, MAT_MOST_NEG, MAT_SMALL,
		MAT_MOST_POS, MAT_PERSPECTIVE, MAT_RANDOM, MAT_IDENTITY
	};

	typedef coord_t matrix_t [NUM_ROWS][NUM_ROWS];

	typedef struct {
		logic                  visible;
		logic [NUM_PLANES-1:0] planes;
	} verdict_t;

	// ------------------------------------------------------------------------
	// outcode predictor and result checker
	// ------------------------------------------------------------------------
	class cull_scoreboard;
		logic [DATA_W-1:0] matrix_regs [NUM_REGS];
		verdict_t          pending_verdicts [$];
		int                errors;
		int                results;
		int                culled;

		function new();
			matrix_regs[REG_ROW0_COLS01] = RST_ROW0_COLS01;
			matrix_regs[REG_ROW0_COLS23] = RST_ROW0_COLS23;
			matrix_regs[REG_ROW1_COLS01] = RST_ROW1_COLS01;
			matrix_regs[REG_ROW1_COLS23] = RST_ROW1_COLS23;
			matrix_regs[REG_ROW2_COLS01] = RST_ROW2_COLS01;
			matrix_regs[REG_ROW2_COLS23] = RST_ROW2_COLS23;
			matrix_regs[REG_ROW3_COLS01] = RST_ROW3_COLS01;
			matrix_regs[REG_ROW3_COLS23] = RST_ROW3_COLS23;
		endfunction

		// indexes past the matrix are dropped
		function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			if (idx < NUM_REGS)
				matrix_regs[idx] = data;
		endfunction

		function coord_t coefficient(int r, int c);
			logic [DATA_W-1:0] word;
			word = matrix_regs[ROW_REG[r][c / 2]];
			return (c % 2) ? word[DATA_W-1:COORD_W] : word[COORD_W-1:0];
		endfunction

		// planes that every transformed corner lies strictly outside of
		function logic [NUM_PLANES-1:0] planes_all_outside(box_t b);
			logic signed [63:0]    pt [NUM_ROWS];
			logic signed [63:0]    hc [NUM_ROWS];
			logic [NUM_PLANES-1:0] code;
			logic [NUM_PLANES-1:0] mask;
			mask = '1;
			for (int k = 0; k < NUM_CORNERS; k++) begin
				pt[0] = k[0] ? b.max_x : b.min_x;
				pt[1] = k[1] ? b.max_y : b.min_y;
				pt[2] = k[2] ? b.max_z : b.min_z;
				pt[3] = 64'sd1 <<< W_SHIFT;
				for (int r = 0; r < NUM_ROWS; r++) begin
					hc[r] = '0;
					for (int c = 0; c < NUM_ROWS; c++)
						hc[r] += coefficient(r, c) * pt[c];
				end
				code = '0;
				for (int a = 0; a < 3; a++) begin
					if (hc[a] < -hc[3])
						code[2 * a] = 1'b1;
					if (hc[a] > hc[3])
						code[2 * a + 1] = 1'b1;
				end
				mask &= code;
			end
			return mask;
		endfunction

		function void note_box(box_t b);
			verdict_t v;
			v.planes  = planes_all_outside(b);
			v.visible = (v.planes == '0);
			pending_verdicts.push_back(v);
		endfunction

		function void check_result(logic vis, logic [NUM_PLANES-1:0] planes);
			verdict_t v;
			results++;
			if (pending_verdicts.size() == 0) begin
				$error("result strobe with no box in flight");
				errors++;
				return;
			end
			v = pending_verdicts.pop_front();
			if (!v.visible)
				culled++;
			if (vis !== v.visible) begin
				$error("visible: expected %0b, got %0b", v.visible, vis);
				errors++;
			end
			if (planes !== v.planes) begin
				$error("all_outside_planes: expected %06b, got %06b", v.planes, planes);
				errors++;
			end
		endfunction

		function int in_flight();
			return pending_verdicts.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block hookup
	// ------------------------------------------------------------------------
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	box_t              drv_box   = '0;
	logic              cfg_valid = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data  = '0;
	logic              busy;
	logic              done;
	logic              visible;
	logic [NUM_PLANES-1:0] all_outside_planes;
	logic              cfg_ready;

	cull_scoreboard sb = new();
	int boxes_sent;
	int cfg_writes;
	int settings_run = 1;    // reset matrix counts as the first setting
	int stall_cycles;

	always #5 clk = ~clk;

	aabb_clip_space_visibility_test_unit DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.min_x              (drv_box.min_x),
		.min_y              (drv_box.min_y),
		.min_z              (drv_box.min_z),
		.max_x              (drv_box.max_x),
		.max_y              (drv_box.max_y),
		.max_z              (drv_box.max_z),
		.done               (done),
		.visible            (visible),
		.all_outside_planes (all_outside_planes),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	// ------------------------------------------------------------------------
	// monitor: every transfer is seen at the edge that completes it
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			// box transfer is noted before the result check so that a
			// result in the same cycle as its box would still find its prediction
			if (start && !busy) begin
				sb.note_box(drv_box);
				boxes_sent++;
				moved = 1'b1;
			end
			if (done) begin
				sb.check_result(visible, all_outside_planes);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
				cfg_writes++;
				moved = 1'b1;
			end
			// watchdog: a hung handshake ends the run
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$error("no transfer for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic coord_t coord_near(int lim);
		return coord_t'($urandom_range(0, 2 * lim) - lim);
	endfunction

	function automatic box_t mk_box(int ax, int ay, int az, int bx, int by, int bz);
		box_t b;
		b.min_x = coord_t'(ax);
		b.min_y = coord_t'(ay);
		b.min_z = coord_t'(az);
		b.max_x = coord_t'(bx);
		b.max_y = coord_t'(by);
		b.max_z = coord_t'(bz);
		return b;
	endfunction

	function automatic matrix_t make_matrix(matrix_kind_t kind);
		matrix_t m;
		for (int r = 0; r < NUM_ROWS; r++)
			for (int c = 0; c < NUM_ROWS; c++)
				case (kind)
					MAT_IDENTITY: m[r][c] = (r == c) ? 16'sd256 : 16'sd0;
					MAT_ZERO:     m[r][c] = 16'sd0;
					MAT_MOST_NEG: m[r][c] = 16'sh8000;
					MAT_MOST_POS: m[r][c] = 16'sh7fff;
					MAT_RANDOM:   m[r][c] = coord_t'($urandom);
					MAT_SMALL:    m[r][c] = coord_near(300);
					default:      m[r][c] = coord_near(32);
				endcase
		// projection-like: scaled diagonal, w taken from -z
		if (kind == MAT_PERSPECTIVE) begin
			m[0][0] = coord_t'($urandom_range(64, 512));
			m[1][1] = coord_t'($urandom_range(64, 512));
			m[2][2] = coord_near(600);
			m[2][3] = coord_near(600);
			m[3][2] = -16'sd256;
			m[3][3] = coord_near(128);
		end
		return m;
	endfunction

	// mostly small boxes that land near the frustum, plus wide and odd ones
	function automatic box_t make_box();
		box_t   b;
		int     pick;
		coord_t lo [3];
		coord_t hi [3];
		pick = $urandom_range(0, 99);
		for (int a = 0; a < 3; a++) begin
			if (pick < 50) begin
				lo[a] = coord_near(1500);
				hi[a] = lo[a] + coord_t'($urandom_range(0, 200));
			end else if (pick < 75) begin
				lo[a] = coord_t'($urandom);
				hi[a] = coord_t'($urandom);
			end else if (pick < 90) begin
				lo[a] = coord_near(600);
				hi[a] = coord_near(600);
			end else begin
				lo[a] = EDGE_VALS[$urandom_range(0, 6)];
				hi[a] = EDGE_VALS[$urandom_range(0, 6)];
			end
		end
		b.min_x = lo[0];
		b.min_y = lo[1];
		b.min_z = lo[2];
		b.max_x = hi[0];
		b.max_y = hi[1];
		b.max_z = hi[2];
		return b;
	endfunction

	// leaves valid high; the caller lowers it once the batch is done
	task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_matrix(matrix_t m);
		for (int r = 0; r < NUM_ROWS; r++)
			for (int h = 0; h < 2; h++)
				cfg_write(ROW_REG[r][h], {m[r][2 * h + 1], m[r][2 * h]});
		// a stray write past the matrix must leave it untouched
		cfg_write(IDX_W'($urandom_range(NUM_REGS, 2 ** IDX_W - 1)), $urandom);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// one box transfer, then, outside a burst, sometimes a random pause
	task automatic push_box(box_t b, bit burst);
		int gap;
		start   <= 1'b1;
		drv_box <= b;
		do @(posedge clk); while (busy);
		if (!burst && $urandom_range(0, 99) >= 45) begin
			gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
			                                   : $urandom_range(8, 40);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and let every box in flight come out
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.in_flight() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(matrix_kind_t kind, int count);
		bit burst;
		burst = 1'b0;
		wait_idle();
		load_matrix(make_matrix(kind));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 4)
				burst = !burst;
			push_box(make_box(), burst);
		end
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix from reset: unit cube is the frustum, planes at +/-256
		push_box(mk_box(0, 0, 0, 0, 0, 0), 1'b0);
		push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 1'b0);
		push_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
		push_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
		push_box(mk_box(-32768, -100, -100, -257, 100, 100), 1'b0);    // left
		push_box(mk_box(-300, -100, -100, -256, 100, 100), 1'b0);      // touching left
		push_box(mk_box(257, -100, -100, 32767, 100, 100), 1'b0);      // right
		push_box(mk_box(256, -100, -100, 300, 100, 100), 1'b0);        // touching right
		push_box(mk_box(-100, -32768, -100, 100, -257, 100), 1'b0);    // bottom
		push_box(mk_box(-100, 257, -100, 100, 32767, 100), 1'b0);      // top
		push_box(mk_box(-100, -100, -32768, 100, 100, -257), 1'b0);    // near
		push_box(mk_box(-100, -100, 257, 100, 100, 32767), 1'b0);      // far
		// min above max, kept as given
		push_box(mk_box(600, 600, 600, 300, 300, 300), 1'b0);
		push_box(mk_box(300, 0, 0, -300, 0, 0), 1'b0);

		// all-zero matrix: strict compares keep everything visible
		wait_idle();
		load_matrix(make_matrix(MAT_ZERO));
		push_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767), 1'b0);
		push_box(mk_box(-32768, 0, 32767, -32768, 0, 32767), 1'b0);

		// identity again, then zeros to every index past the matrix
		wait_idle();
		load_matrix(make_matrix(MAT_IDENTITY));
		for (int x = NUM_REGS; x < 2 ** IDX_W; x++)
			cfg_write(IDX_W'(x), '0);
		cfg_valid <= 1'b0;
		push_box(mk_box(-32768, -100, -100, -257, 100, 100), 1'b0);
		push_box(mk_box(257, 257, 257, 32767, 32767, 32767), 1'b0);

		// random boxes under a spread of matrix settings
		foreach (PHASE_KINDS[p])
			run_phase(PHASE_KINDS[p], PHASE_BOXES);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d boxes under %0d matrix settings, %0d register writes",
			boxes_sent, settings_run, cfg_writes);
		$display("checked %0d results, %0d culled by at least one plane, %0d errors",
			sb.results, sb.culled, sb.errors);
		if (sb.errors == 0 && sb.in_flight() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
src/aabb_pkg.sv
src/aabb_row_xform.sv
src/aabb_clip_space_visibility_test_unit.sv
verif/aabb_clip_space_visibility_test_unit_test.sv
